// File: rtl/core/vabr_pkg.sv
package vabr_pkg;

	localparam int COORD_WIDTH         = 16;
	localparam int CORDIC_STAGES       = 16;
	localparam int ANGLE_FRACTION_BITS = 6;

	localparam int GUARD_BITS = 8;
	localparam int ZFRAC      = 16;
	localparam int TABLE_LEN  = 24;

	// difference of two coordinates, then magnitude with guard bits and cordic growth
	localparam int DW  = COORD_WIDTH + 1;
	localparam int XW  = DW + GUARD_BITS + 3;
	localparam int ZW  = 26;
	localparam int TW  = 25;
	localparam int AW  = 15;
	localparam int SHW = $clog2(TABLE_LEN);
	localparam int RSH = ZFRAC - ANGLE_FRACTION_BITS;

	localparam logic [AW-1:0] FULL_ANG = AW'(360 << ANGLE_FRACTION_BITS);
	localparam logic [AW-1:0] ANG_90   = AW'(90 << ANGLE_FRACTION_BITS);
	localparam logic [AW-1:0] ANG_180  = AW'(180 << ANGLE_FRACTION_BITS);
	localparam logic [AW-1:0] ANG_270  = AW'(270 << ANGLE_FRACTION_BITS);

	localparam logic [TW-1:0] DEG_90   = TW'(90 << ZFRAC);
	localparam logic [TW-1:0] DEG_180  = TW'(180 << ZFRAC);
	localparam logic [TW-1:0] DEG_360  = TW'(360 << ZFRAC);
	localparam logic [TW-1:0] HALF_OUT = TW'(1 << (RSH - 1));

	// arctangent of 2^-i in units of 2^-16 degree
	localparam logic [ZW-1:0] ATAN_TABLE [TABLE_LEN] = '{
		ZW'(2949120), ZW'(1740967), ZW'(919879), ZW'(466945),
		ZW'(234379),  ZW'(117304),  ZW'(58666),  ZW'(29335),
		ZW'(14668),   ZW'(7334),    ZW'(3667),   ZW'(1833),
		ZW'(917),     ZW'(458),     ZW'(229),    ZW'(115),
		ZW'(57),      ZW'(29),      ZW'(14),     ZW'(7),
		ZW'(4),       ZW'(2),       ZW'(1),      ZW'(0)
	};

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 neg_x;
		logic                 neg_v;
		logic                 fixed;
		logic [AW-1:0]        fixed_ang;
	} ray_t;

	typedef struct packed {
		ray_t a;
		ray_t b;
	} pair_t;

	typedef struct packed {
		logic [AW-1:0] first;
		logic [AW-1:0] second;
	} angles_t;

endpackage

// File: rtl/core/vabr_prep.sv
module vabr_prep import vabr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   operation,
	input  logic [COORD_WIDTH-1:0] point_a_x,
	input  logic [COORD_WIDTH-1:0] point_a_y,
	input  logic [COORD_WIDTH-1:0] point_a_z,
	input  logic [COORD_WIDTH-1:0] vertex_x,
	input  logic [COORD_WIDTH-1:0] vertex_y,
	input  logic [COORD_WIDTH-1:0] vertex_z,
	input  logic [COORD_WIDTH-1:0] point_b_x,
	input  logic [COORD_WIDTH-1:0] point_b_y,
	input  logic [COORD_WIDTH-1:0] point_b_z,
	output logic                   out_valid,
	input  logic                   out_ready,
	output pair_t                  out_data
);

	logic  valid_q;
	pair_t data_q;
	pair_t data_d;

	function automatic logic signed [DW-1:0] diff(logic [COORD_WIDTH-1:0] p,
			logic [COORD_WIDTH-1:0] v);
		return $signed({p[COORD_WIDTH-1], p}) - $signed({v[COORD_WIDTH-1], v});
	endfunction

	function automatic ray_t make_ray(logic signed [DW-1:0] dx, logic signed [DW-1:0] dv);
		ray_t          r;
		logic [DW-1:0] mx;
		logic [DW-1:0] mv;
		mx = dx[DW-1] ? DW'(-dx) : DW'(dx);
		mv = dv[DW-1] ? DW'(-dv) : DW'(dv);
		r.x = $signed({{(XW-DW-GUARD_BITS){1'b0}}, mx, {GUARD_BITS{1'b0}}});
		r.y = $signed({{(XW-DW-GUARD_BITS){1'b0}}, mv, {GUARD_BITS{1'b0}}});
		r.z = '0;
		r.neg_x = dx[DW-1];
		r.neg_v = dv[DW-1];
		r.fixed = 1'b0;
		r.fixed_ang = '0;
		// vertical ray, coincident points included
		if (dx == '0) begin
			r.fixed = 1'b1;
			r.fixed_ang = (!dv[DW-1] && dv != '0) ? ANG_90 : ANG_270;
		end else if (dv == '0) begin
			r.fixed = 1'b1;
			r.fixed_ang = dx[DW-1] ? ANG_180 : '0;
		end
		return r;
	endfunction

	always_comb begin
		data_d.a = make_ray(diff(point_a_x, vertex_x),
			operation ? diff(point_a_z, vertex_z) : diff(point_a_y, vertex_y));
		data_d.b = make_ray(diff(point_b_x, vertex_x),
			operation ? diff(point_b_z, vertex_z) : diff(point_b_y, vertex_y));
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= data_d;
		end
	end

endmodule

// File: rtl/core/vabr_cell.sv
module vabr_cell import vabr_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  pair_t          in_data,
	input  logic [SHW-1:0] shift,
	input  logic [ZW-1:0]  atan,
	output logic           out_valid,
	input  logic           out_ready,
	output pair_t          out_data
);

	logic  valid_q;
	pair_t data_q;
	pair_t data_d;

	// one vectoring micro-rotation toward the x axis
	function automatic ray_t rotate(ray_t r, logic [SHW-1:0] sh, logic [ZW-1:0] a);
		ray_t                 o;
		logic signed [XW-1:0] xs;
		logic signed [XW-1:0] ys;
		o = r;
		xs = $signed(r.x) >>> sh;
		ys = $signed(r.y) >>> sh;
		if (!r.y[XW-1]) begin
			o.x = r.x + ys;
			o.y = r.y - xs;
			o.z = r.z + $signed(a);
		end else begin
			o.x = r.x - ys;
			o.y = r.y + xs;
			o.z = r.z - $signed(a);
		end
		return o;
	endfunction

	always_comb begin
		data_d.a = rotate(in_data.a, shift, atan);
		data_d.b = rotate(in_data.b, shift, atan);
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= data_d;
		end
	end

endmodule

// File: rtl/core/vabr_post.sv
module vabr_post import vabr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  pair_t   in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output angles_t out_data
);

	logic    valid_q;
	angles_t data_q;
	angles_t data_d;

	// clamp to the first quadrant, unfold, round to the output unit
	function automatic logic [AW-1:0] finish(ray_t r);
		logic [TW-1:0] zc;
		logic [TW-1:0] t;
		logic [TW-1:0] tr;
		logic [AW-1:0] ang;
		if (r.z[ZW-1]) begin
			zc = '0;
		end else if (r.z[ZW-2:0] > {{(ZW-1-TW){1'b0}}, DEG_90}) begin
			zc = DEG_90;
		end else begin
			zc = r.z[TW-1:0];
		end
		case ({r.neg_x, r.neg_v})
			2'b00:   t = zc;
			2'b10:   t = DEG_180 - zc;
			2'b11:   t = DEG_180 + zc;
			default: t = DEG_360 - zc;
		endcase
		tr = t + HALF_OUT;
		ang = tr[TW-1:RSH];
		if (ang >= FULL_ANG) begin
			ang = ang - FULL_ANG;
		end
		return r.fixed ? r.fixed_ang : ang;
	endfunction

	always_comb begin
		data_d.first  = finish(in_data.a);
		data_d.second = finish(in_data.b);
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= data_d;
		end
	end

endmodule

// File: rtl/core/vertex_angle_between_rays.sv
// Vertex angle unit: for each request of three points A, V, B it returns the directions of
// rays V->A and V->B in the x-y plane (operation 0) or the x-z plane (operation 1), and
// their difference modulo 360, all in 1/64 degree. A request is taken every cycle while the
// output side is not stalled; each one passes a prep stage, a row of 16 CORDIC cells (one
// micro-rotation per cell, both rays side by side), an unfold/round stage and the output
// register. Every stage has its own valid bit and moves whenever the stage after it is
// empty or moving.
module vertex_angle_between_rays import vabr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   operation,
	input  logic [COORD_WIDTH-1:0] point_a_x,
	input  logic [COORD_WIDTH-1:0] point_a_y,
	input  logic [COORD_WIDTH-1:0] point_a_z,
	input  logic [COORD_WIDTH-1:0] vertex_x,
	input  logic [COORD_WIDTH-1:0] vertex_y,
	input  logic [COORD_WIDTH-1:0] vertex_z,
	input  logic [COORD_WIDTH-1:0] point_b_x,
	input  logic [COORD_WIDTH-1:0] point_b_y,
	input  logic [COORD_WIDTH-1:0] point_b_z,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [AW-1:0]          vertex_angle,
	output logic [AW-1:0]          first_ray_angle,
	output logic [AW-1:0]          second_ray_angle
);

	logic    chain_valid [CORDIC_STAGES+1];
	logic    chain_ready [CORDIC_STAGES+1];
	pair_t   chain_data  [CORDIC_STAGES+1];

	logic    post_valid;
	logic    post_ready;
	angles_t post_data;

	logic          out_valid_q;
	logic [AW-1:0] vertex_angle_q;
	logic [AW-1:0] first_q;
	logic [AW-1:0] second_q;
	logic [AW:0]   span;

	vabr_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.point_a_x (point_a_x),
		.point_a_y (point_a_y),
		.point_a_z (point_a_z),
		.vertex_x  (vertex_x),
		.vertex_y  (vertex_y),
		.vertex_z  (vertex_z),
		.point_b_x (point_b_x),
		.point_b_y (point_b_y),
		.point_b_z (point_b_z),
		.out_valid (chain_valid[0]),
		.out_ready (chain_ready[0]),
		.out_data  (chain_data[0])
	);

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		vabr_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[i]),
			.in_ready  (chain_ready[i]),
			.in_data   (chain_data[i]),
			.shift     (SHW'(i)),
			.atan      (ATAN_TABLE[i]),
			.out_valid (chain_valid[i+1]),
			.out_ready (chain_ready[i+1]),
			.out_data  (chain_data[i+1])
		);
	end

	vabr_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chain_valid[CORDIC_STAGES]),
		.in_ready  (chain_ready[CORDIC_STAGES]),
		.in_data   (chain_data[CORDIC_STAGES]),
		.out_valid (post_valid),
		.out_ready (post_ready),
		.out_data  (post_data)
	);

	// second minus first, folded back into one turn
	always_comb begin
		if (post_data.second >= post_data.first) begin
			span = {1'b0, post_data.second} - {1'b0, post_data.first};
		end else begin
			span = {1'b0, post_data.second} + {1'b0, FULL_ANG} - {1'b0, post_data.first};
		end
	end

	assign post_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (post_ready) begin
			out_valid_q <= post_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (post_ready && post_valid) begin
			vertex_angle_q <= span[AW-1:0];
			first_q        <= post_data.first;
			second_q       <= post_data.second;
		end
	end

	assign out_valid        = out_valid_q;
	assign vertex_angle     = vertex_angle_q;
	assign first_ray_angle  = first_q;
	assign second_ray_angle = second_q;

endmodule

// File: rtl/core/vabr_checker.sv
module vabr_checker import vabr_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input logic [AW-1:0] vertex_angle,
	input logic [AW-1:0] first_ray_angle,
	input logic [AW-1:0] second_ray_angle
);

	// a held result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(vertex_angle)
			&& $stable(first_ray_angle) && $stable(second_ray_angle))
		else $error("result changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> first_ray_angle < FULL_ANG && second_ray_angle < FULL_ANG
			&& vertex_angle < FULL_ANG)
		else $error("angle outside one turn");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (second_ray_angle >= first_ray_angle
			&& vertex_angle == second_ray_angle - first_ray_angle)
			|| (second_ray_angle < first_ray_angle
			&& vertex_angle == AW'(second_ray_angle + FULL_ANG - first_ray_angle)))
		else $error("vertex angle does not match ray angles");

	// an empty output register means the whole chain can move
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("request refused with output empty");

endmodule

bind vertex_angle_between_rays vabr_checker u_vabr_checker (.*);

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top import vabr_pkg::*;;

	localparam bit OP_AZIMUTH = 1'b0;
	localparam bit OP_ZENITH  = 1'b1;

	localparam int RANDOM_REQS = 2000;
	localparam int SETTLE_CYCLES = 40;

	// cordic angle accumulator works in 2^-16 degree
	localparam int     Q16_BITS    = 16;
	localparam int     GUARD_SHIFT = 8;
	localparam longint DEG_UNIT    = longint'(1) << Q16_BITS;
	localparam int     OUT_SHIFT   = Q16_BITS - ANGLE_FRACTION_BITS;
	localparam int     FULL_TURN   = 360 << ANGLE_FRACTION_BITS;
	localparam int     ANGLE_UP    = 90 << ANGLE_FRACTION_BITS;
	localparam int     ANGLE_BACK  = 180 << ANGLE_FRACTION_BITS;
	localparam int     ANGLE_DOWN  = 270 << ANGLE_FRACTION_BITS;
	localparam int     ATAN_LEN    = 24;

	localparam longint ATAN_Q16 [ATAN_LEN] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	typedef struct {
		bit                     operation;
		logic [COORD_WIDTH-1:0] ax, ay, az;
		logic [COORD_WIDTH-1:0] vx, vy, vz;
		logic [COORD_WIDTH-1:0] bx, by, bz;
		bit                     drain;
	} ray_req_t;

	typedef struct {
		logic [AW-1:0] vertex;
		logic [AW-1:0] first;
		logic [AW-1:0] second;
	} ray_angles_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic operation = 1'b0;
	logic [COORD_WIDTH-1:0] point_a_x = '0;
	logic [COORD_WIDTH-1:0] point_a_y = '0;
	logic [COORD_WIDTH-1:0] point_a_z = '0;
	logic [COORD_WIDTH-1:0] vertex_x = '0;
	logic [COORD_WIDTH-1:0] vertex_y = '0;
	logic [COORD_WIDTH-1:0] vertex_z = '0;
	logic [COORD_WIDTH-1:0] point_b_x = '0;
	logic [COORD_WIDTH-1:0] point_b_y = '0;
	logic [COORD_WIDTH-1:0] point_b_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [AW-1:0] vertex_angle;
	logic [AW-1:0] first_ray_angle;
	logic [AW-1:0] second_ray_angle;

	ray_req_t    req_backlog [$];
	ray_angles_t angles_due [$];
	ray_req_t    send_item;
	logic        req_fire = 1'b0;
	int          send_gap = 0;
	int          send_calm = 0;
	int          recv_gap = 0;
	int          recv_calm = 0;
	int          mismatches = 0;

	vertex_angle_between_rays DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.operation        (operation),
		.point_a_x        (point_a_x),
		.point_a_y        (point_a_y),
		.point_a_z        (point_a_z),
		.vertex_x         (vertex_x),
		.vertex_y         (vertex_y),
		.vertex_z         (vertex_z),
		.point_b_x        (point_b_x),
		.point_b_y        (point_b_y),
		.point_b_z        (point_b_z),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.vertex_angle     (vertex_angle),
		.first_ray_angle  (first_ray_angle),
		.second_ray_angle (second_ray_angle)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#4ms;
		$display("vertex_angle_between_rays: mismatch");
		$finish;
	end

	// direction of (dx, dv) in output units, cordic in vectoring mode
	function automatic logic [AW-1:0] ray_direction(longint dx, longint dv);
		longint x, y, z, xs, ys, t;
		longint unsigned rounded;
		if (dx == 0)
			return (dv > 0) ? AW'(ANGLE_UP) : AW'(ANGLE_DOWN);
		if (dv == 0)
			return (dx > 0) ? AW'(0) : AW'(ANGLE_BACK);
		x = (dx < 0 ? -dx : dx) * (longint'(1) << GUARD_SHIFT);
		y = (dv < 0 ? -dv : dv) * (longint'(1) << GUARD_SHIFT);
		z = 0;
		for (int i = 0; i < CORDIC_STAGES && i < ATAN_LEN; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + ATAN_Q16[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - ATAN_Q16[i];
			end
		end
		if (z < 0)
			z = 0;
		if (z > 90 * DEG_UNIT)
			z = 90 * DEG_UNIT;
		// unfold the first-quadrant angle
		if (dx > 0 && dv > 0)
			t = z;
		else if (dx < 0 && dv > 0)
			t = 180 * DEG_UNIT - z;
		else if (dx < 0)
			t = 180 * DEG_UNIT + z;
		else
			t = 360 * DEG_UNIT - z;
		rounded = unsigned'(t + (longint'(1) << (OUT_SHIFT - 1))) >> OUT_SHIFT;
		if (rounded >= FULL_TURN)
			rounded = rounded - FULL_TURN;
		return rounded[AW-1:0];
	endfunction

	function automatic ray_angles_t predict_angles(ray_req_t r);
		longint dxa, dva, dxb, dvb;
		ray_angles_t res;
		dxa = longint'($signed(r.ax)) - longint'($signed(r.vx));
		dxb = longint'($signed(r.bx)) - longint'($signed(r.vx));
		if (r.operation == OP_ZENITH) begin
			dva = longint'($signed(r.az)) - longint'($signed(r.vz));
			dvb = longint'($signed(r.bz)) - longint'($signed(r.vz));
		end else begin
			dva = longint'($signed(r.ay)) - longint'($signed(r.vy));
			dvb = longint'($signed(r.by)) - longint'($signed(r.vy));
		end
		res.first = ray_direction(dxa, dva);
		res.second = ray_direction(dxb, dvb);
		if (res.second >= res.first)
			res.vertex = res.second - res.first;
		else
			res.vertex = AW'(int'(res.second) + FULL_TURN - int'(res.first));
		return res;
	endfunction

	// mostly short gaps, a few long ones, and now and then a calm stretch with none
	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm = calm - 1;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic logic [COORD_WIDTH-1:0] near_coord(logic [COORD_WIDTH-1:0] base);
		return base + COORD_WIDTH'($urandom_range(0, 8)) - COORD_WIDTH'(4);
	endfunction

	function automatic logic [COORD_WIDTH-1:0] edge_coord();
		case ($urandom_range(0, 5))
			0: return {1'b1, {(COORD_WIDTH-1){1'b0}}};
			1: return {1'b0, {(COORD_WIDTH-1){1'b1}}};
			2: return '0;
			3: return '1;
			4: return COORD_WIDTH'(1);
			default: return COORD_WIDTH'($urandom);
		endcase
	endfunction

	task automatic add_req(input bit op, input int ax, ay, az, vx, vy, vz, bx, by, bz);
		ray_req_t r;
		r.operation = op;
		r.ax = COORD_WIDTH'(ax);
		r.ay = COORD_WIDTH'(ay);
		r.az = COORD_WIDTH'(az);
		r.vx = COORD_WIDTH'(vx);
		r.vy = COORD_WIDTH'(vy);
		r.vz = COORD_WIDTH'(vz);
		r.bx = COORD_WIDTH'(bx);
		r.by = COORD_WIDTH'(by);
		r.bz = COORD_WIDTH'(bz);
		r.drain = 1'b0;
		req_backlog.push_back(r);
	endtask

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || req_fire) begin
			if (send_gap > 0) begin
				send_gap = send_gap - 1;
				in_valid <= 1'b0;
			end else if (req_backlog.size() != 0 &&
					!(req_backlog[0].drain && angles_due.size() != 0)) begin
				send_item = req_backlog.pop_front();
				operation <= send_item.operation;
				point_a_x <= send_item.ax;
				point_a_y <= send_item.ay;
				point_a_z <= send_item.az;
				vertex_x <= send_item.vx;
				vertex_y <= send_item.vy;
				vertex_z <= send_item.vz;
				point_b_x <= send_item.bx;
				point_b_y <= send_item.by;
				point_b_z <= send_item.bz;
				in_valid <= 1'b1;
				send_gap = pick_gap(send_calm);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap = recv_gap - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				recv_gap = pick_gap(recv_calm);
		end
	end

	// monitor
	always @(posedge clk) begin
		ray_req_t seen;
		ray_angles_t want;
		req_fire <= in_valid && in_ready;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				seen.operation = operation;
				seen.ax = point_a_x;
				seen.ay = point_a_y;
				seen.az = point_a_z;
				seen.vx = vertex_x;
				seen.vy = vertex_y;
				seen.vz = vertex_z;
				seen.bx = point_b_x;
				seen.by = point_b_y;
				seen.bz = point_b_z;
				seen.drain = 1'b0;
				angles_due.push_back(predict_angles(seen));
			end
			if (out_valid && out_ready) begin
				if (angles_due.size() == 0) begin
					$error("result with no request outstanding");
					mismatches++;
				end else begin
					want = angles_due.pop_front();
					if (vertex_angle !== want.vertex) begin
						$error("vertex_angle: expected %0d, got %0d", want.vertex, vertex_angle);
						mismatches++;
					end
					if (first_ray_angle !== want.first) begin
						$error("first_ray_angle: expected %0d, got %0d",
							want.first, first_ray_angle);
						mismatches++;
					end
					if (second_ray_angle !== want.second) begin
						$error("second_ray_angle: expected %0d, got %0d",
							want.second, second_ray_angle);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin
		ray_req_t r;
		int kind;

		// coincident points in both planes
		add_req(OP_AZIMUTH, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_req(OP_ZENITH, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		// horizontal rays
		add_req(OP_AZIMUTH, 5, 0, 9, 0, 0, 0, -5, 0, -9);
		add_req(OP_ZENITH, 7, 3, 2, 2, 8, 2, -40, -1, 2);
		// vertical rays
		add_req(OP_AZIMUTH, 0, 7, 1, 0, 0, 0, 0, -7, 1);
		add_req(OP_ZENITH, 0, 100, 3, 0, 0, 0, 0, -100, -3);
		// largest differences
		add_req(OP_AZIMUTH, 32767, 32767, 32767, -32768, -32768, -32768,
			-32768, -32768, -32768);
		add_req(OP_ZENITH, -32768, -32768, -32768, 32767, 32767, 32767,
			32767, -32768, -32768);
		add_req(OP_AZIMUTH, -32768, 32767, 0, 32767, -32768, 0, 32767, 32767, 0);
		// diagonals and all quadrants
		add_req(OP_AZIMUTH, 100, 100, 0, 0, 0, 0, -100, -100, 0);
		add_req(OP_ZENITH, 3, 0, -4, 0, 0, 0, -3, 0, 4);
		add_req(OP_AZIMUTH, -3, 4, 0, 0, 0, 0, 3, -4, 0);
		// just off the vertical and the horizontal axes
		add_req(OP_AZIMUTH, 1, 32767, 0, 0, -32768, 0, -1, 32767, 0);
		add_req(OP_ZENITH, 1, 0, -32768, 0, 0, 32767, -1, 0, -32768);
		add_req(OP_AZIMUTH, 32767, 1, 0, -32768, 0, 0, 32767, -1, 0);
		add_req(OP_ZENITH, -32768, 0, 1, 32767, 0, 0, -32768, 0, -1);
		// plane selection: y and z disagree
		add_req(OP_AZIMUTH, 10, 20, -30, 0, 0, 0, -10, -20, 30);
		add_req(OP_ZENITH, 10, 20, -30, 0, 0, 0, -10, -20, 30);
		// second ray behind the first, difference wraps
		add_req(OP_AZIMUTH, -10, -1, 0, 0, 0, 0, 10, 1, 0);

		for (int n = 0; n < RANDOM_REQS; n++) begin
			kind = $urandom_range(0, 19);
			r.operation = $urandom_range(0, 1) ? OP_ZENITH : OP_AZIMUTH;
			r.vx = COORD_WIDTH'($urandom);
			r.vy = COORD_WIDTH'($urandom);
			r.vz = COORD_WIDTH'($urandom);
			r.ax = COORD_WIDTH'($urandom);
			r.ay = COORD_WIDTH'($urandom);
			r.az = COORD_WIDTH'($urandom);
			r.bx = COORD_WIDTH'($urandom);
			r.by = COORD_WIDTH'($urandom);
			r.bz = COORD_WIDTH'($urandom);
			if (kind >= 10 && kind < 14) begin
				r.ax = near_coord(r.vx);
				r.ay = near_coord(r.vy);
				r.az = near_coord(r.vz);
				r.bx = near_coord(r.vx);
				r.by = near_coord(r.vy);
				r.bz = near_coord(r.vz);
			end else if (kind == 14) begin
				r.ax = r.vx;
				r.by = r.vy;
				r.bz = r.vz;
			end else if (kind == 15) begin
				r.ay = r.vy;
				r.az = r.vz;
				r.bx = r.vx;
			end else if (kind == 16) begin
				r.ax = r.vx;
				r.bx = r.vx;
				r.by = r.vy;
				r.bz = r.vz;
			end else if (kind >= 17) begin
				r.vx = edge_coord();
				r.vy = edge_coord();
				r.vz = edge_coord();
				r.ax = edge_coord();
				r.ay = edge_coord();
				r.az = edge_coord();
				r.bx = edge_coord();
				r.by = edge_coord();
				r.bz = edge_coord();
			end
			// let the pipeline empty completely now and then
			r.drain = (n % 600 == 300);
			req_backlog.push_back(r);
		end

		while (req_backlog.size() != 0 || in_valid)
			@(posedge clk);
		while (angles_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("vertex_angle_between_rays: match");
		else
			$display("vertex_angle_between_rays: mismatch");
		$finish;
	end

endmodule
